### sv/hlos_pkg.sv
// Shared types, constants and helpers for the heightmap line-of-sight block.
`timescale 1ns / 1ps
package hlos_pkg;

   // Map and sample sizing
   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 512;
   localparam int HEIGHT_BITS = 16;

   // Fixed field widths
   localparam int CRD_BITS  = 9;     // cell_x, cell_y, observer_x, observer_y
   localparam int DIM_BITS  = 10;    // map_width, map_height
   localparam int OFS_BITS  = 16;    // observer_offset, target_offset
   localparam int HV_BITS   = 16;    // height_value
   localparam int IDX_BITS  = 3;     // register index on the csr channel
   localparam int REQ_BITS  = 40;    // req_tdata, padded to bytes
   localparam int RSP_BITS  = 24;    // rsp_tdata, padded to bytes

   // Store geometry
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   // Walk arithmetic widths
   localparam int STEP_BITS = CRD_BITS + 1;
   localparam int ERR_BITS  = STEP_BITS + 2;
   localparam int AB_BITS   = ((HEIGHT_BITS > OFS_BITS) ? HEIGHT_BITS : OFS_BITS) + 2;
   localparam int DLT_BITS  = AB_BITS + 1;
   localparam int RAY_BITS  = AB_BITS + STEP_BITS + 1;
   localparam int GND_BITS  = HEIGHT_BITS + STEP_BITS;

   // Queue between front and back (depth must be a power of two)
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);

   // Register indexes
   typedef enum logic [IDX_BITS-1:0] {
      REG_MAP_WIDTH       = 3'd0,
      REG_MAP_HEIGHT      = 3'd1,
      REG_OBSERVER_X      = 3'd2,
      REG_OBSERVER_Y      = 3'd3,
      REG_OBSERVER_OFFSET = 3'd4,
      REG_TARGET_OFFSET   = 3'd5
   } reg_index_type;

   // Item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [DIM_BITS-1:0] map_width;
      logic [DIM_BITS-1:0] map_height;
      logic [CRD_BITS-1:0] observer_x;
      logic [CRD_BITS-1:0] observer_y;
      logic [OFS_BITS-1:0] observer_offset;
      logic [OFS_BITS-1:0] target_offset;
   } cfg_type;

   // One classified item in the queue; coordinates already saturated
   typedef struct packed {
      logic                is_query;
      logic [CRD_BITS-1:0] x;
      logic [CRD_BITS-1:0] y;
      logic [HV_BITS-1:0]  hv;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Clamp a coordinate to [0, clamp(dim, 1, max_dim) - 1]
   function automatic logic [CRD_BITS-1:0] sat_coord(input logic [CRD_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] dim,
                                                     input int max_dim);
      logic [31:0] lim;
      if (dim == '0) begin
         lim = '0;
      end else if (32'(dim) > 32'(max_dim)) begin
         lim = 32'(max_dim) - 32'd1;
      end else begin
         lim = 32'(dim) - 32'd1;
      end
      return (32'(v) > lim) ? lim[CRD_BITS-1:0] : v;
   endfunction

endpackage

### sv/hlos_fifo.sv
// Short item queue between the classifying front and the walking back end.
`timescale 1ns / 1ps
module hlos_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hlos_pkg::item_type push_item,
   input  logic               pop,
   output hlos_pkg::item_type head_item,
   output hlos_pkg::qstat_type stat
);

   hlos_pkg::item_type                  slot_ff [hlos_pkg::QDEPTH];
   logic [hlos_pkg::QPTR_BITS-1:0]      wr_ptr_ff;
   logic [hlos_pkg::QPTR_BITS-1:0]      rd_ptr_ff;
   logic [hlos_pkg::QPTR_BITS:0]        count_ff;

   assign stat.full  = (count_ff == (hlos_pkg::QPTR_BITS + 1)'(hlos_pkg::QDEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### sv/hlos_front.sv
// Front end: accepts request transfers, saturates coordinates, drops off-map writes.
`timescale 1ns / 1ps
module hlos_front (
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hlos_pkg::REQ_BITS-1:0]  req_tdata,
   input  logic                           req_tuser,
   input  hlos_pkg::cfg_type              cfg,
   input  hlos_pkg::qstat_type            q_stat,
   output logic                           q_push,
   output hlos_pkg::item_type             q_item
);

   logic [hlos_pkg::CRD_BITS-1:0] cell_x;
   logic [hlos_pkg::CRD_BITS-1:0] cell_y;
   logic [hlos_pkg::HV_BITS-1:0]  height_value;
   logic [hlos_pkg::CRD_BITS-1:0] sat_x;
   logic [hlos_pkg::CRD_BITS-1:0] sat_y;
   logic                          in_map;
   logic                          is_query;

   // Unpack request fields
   assign cell_x       = req_tdata[hlos_pkg::CRD_BITS-1:0];
   assign cell_y       = req_tdata[2*hlos_pkg::CRD_BITS-1:hlos_pkg::CRD_BITS];
   assign height_value = req_tdata[2*hlos_pkg::CRD_BITS+hlos_pkg::HV_BITS-1:
                                   2*hlos_pkg::CRD_BITS];
   assign is_query     = (req_tuser == hlos_pkg::KIND_QUERY);

   // Saturate to the map in use; a cell is on the map when saturation leaves it alone
   assign sat_x  = hlos_pkg::sat_coord(cell_x, cfg.map_width, hlos_pkg::MAX_WIDTH);
   assign sat_y  = hlos_pkg::sat_coord(cell_y, cfg.map_height, hlos_pkg::MAX_HEIGHT);
   assign in_map = (sat_x == cell_x) && (sat_y == cell_y);

   assign req_tready = !q_stat.full;

   // Off-map writes are consumed here and never queued
   assign q_push          = req_tvalid && req_tready && (is_query || in_map);
   assign q_item.is_query = is_query;
   assign q_item.x        = sat_x;
   assign q_item.y        = sat_y;
   assign q_item.hv       = height_value;

endmodule

### sv/hlos_back.sv
// Back end: height store, ray walker with read/multiply/compare pipeline, result register.
`timescale 1ns / 1ps
module hlos_back (
   input  logic                           clock,
   input  logic                           reset,
   input  hlos_pkg::cfg_type              cfg,
   input  hlos_pkg::item_type             q_head,
   input  hlos_pkg::qstat_type            q_stat,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hlos_pkg::CRD_BITS-1:0]  rsp_target_x,
   output logic [hlos_pkg::CRD_BITS-1:0]  rsp_target_y,
   output logic                           rsp_shadowed
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_OBS,
      S_TGT,
      S_AB,
      S_MUL,
      S_WALK,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type state_ff;

   // Height store
   logic [hlos_pkg::HEIGHT_BITS-1:0] hmem [hlos_pkg::STORE_DEPTH];
   logic [hlos_pkg::HEIGHT_BITS-1:0] rd_data_ff;
   logic [hlos_pkg::ADDR_BITS-1:0]   rd_addr;
   logic [hlos_pkg::ADDR_BITS-1:0]   wr_addr;
   logic                             wr_en;
   logic [hlos_pkg::CRD_BITS-1:0]    rd_x;
   logic [hlos_pkg::CRD_BITS-1:0]    rd_y;

   // Query geometry
   logic [hlos_pkg::CRD_BITS-1:0]  obs_x;
   logic [hlos_pkg::CRD_BITS-1:0]  obs_y;
   logic [hlos_pkg::CRD_BITS-1:0]  adx_in;
   logic [hlos_pkg::CRD_BITS-1:0]  ady_in;
   logic [hlos_pkg::STEP_BITS-1:0] steps_in;
   logic [hlos_pkg::CRD_BITS-1:0]  x1_ff;
   logic [hlos_pkg::CRD_BITS-1:0]  y1_ff;
   logic [hlos_pkg::CRD_BITS-1:0]  adx_ff;
   logic [hlos_pkg::CRD_BITS-1:0]  ady_ff;
   logic                           xneg_ff;
   logic                           yneg_ff;
   logic [hlos_pkg::STEP_BITS-1:0] steps_ff;

   // Ray end heights and running ray value
   logic signed [hlos_pkg::AB_BITS-1:0]  a_ff;
   logic signed [hlos_pkg::AB_BITS-1:0]  b_ff;
   logic signed [hlos_pkg::DLT_BITS-1:0] dlt_ff;
   logic signed [hlos_pkg::RAY_BITS-1:0] ray_ff;
   logic signed [hlos_pkg::RAY_BITS-1:0] mul_a;
   logic signed [hlos_pkg::RAY_BITS-1:0] mul_s;
   logic signed [hlos_pkg::RAY_BITS-1:0] ray_start;

   // Walker
   logic [hlos_pkg::CRD_BITS-1:0]  px_ff;
   logic [hlos_pkg::CRD_BITS-1:0]  py_ff;
   logic [hlos_pkg::ERR_BITS-1:0]  ex_ff;
   logic [hlos_pkg::ERR_BITS-1:0]  ey_ff;
   logic [hlos_pkg::STEP_BITS-1:0] left_ff;
   logic [hlos_pkg::ERR_BITS-1:0]  ex_sum;
   logic [hlos_pkg::ERR_BITS-1:0]  ey_sum;
   logic [hlos_pkg::ERR_BITS-1:0]  two_steps;

   // Check pipeline: read, multiply, compare
   logic                                 v1_ff;
   logic                                 l1_ff;
   logic signed [hlos_pkg::RAY_BITS-1:0] ray1_ff;
   logic                                 v2_ff;
   logic                                 l2_ff;
   logic signed [hlos_pkg::RAY_BITS-1:0] ray2_ff;
   logic [hlos_pkg::GND_BITS-1:0]        gnd2_ff;
   logic                                 hit;
   logic                                 shadow_ff;

   // Result register
   logic                          rsp_valid_ff;
   logic [hlos_pkg::CRD_BITS-1:0] rsp_x_ff;
   logic [hlos_pkg::CRD_BITS-1:0] rsp_y_ff;
   logic                          rsp_shadow_ff;

   // Observer cell within the map in use
   assign obs_x = hlos_pkg::sat_coord(cfg.observer_x, cfg.map_width, hlos_pkg::MAX_WIDTH);
   assign obs_y = hlos_pkg::sat_coord(cfg.observer_y, cfg.map_height, hlos_pkg::MAX_HEIGHT);

   // Distances and step count for the query at the queue head
   assign adx_in = (q_head.x >= obs_x) ? (q_head.x - obs_x) : (obs_x - q_head.x);
   assign ady_in = (q_head.y >= obs_y) ? (q_head.y - obs_y) : (obs_y - q_head.y);
   always_comb begin
      steps_in = (adx_in > ady_in) ? hlos_pkg::STEP_BITS'(adx_in)
                                   : hlos_pkg::STEP_BITS'(ady_in);
      if (steps_in == '0) begin
         steps_in = hlos_pkg::STEP_BITS'(1);
      end
   end

   // Queue handshake: writes finish on pop, queries start on pop
   assign q_pop   = (state_ff == S_IDLE) && !q_stat.empty;
   assign wr_en   = q_pop && !q_head.is_query;
   assign wr_addr = hlos_pkg::ADDR_BITS'(q_head.y) * hlos_pkg::ADDR_BITS'(hlos_pkg::MAX_WIDTH)
                  + hlos_pkg::ADDR_BITS'(q_head.x);

   // Read address: observer, target, then walk points
   always_comb begin
      case (state_ff)
         S_OBS: begin
            rd_x = obs_x;
            rd_y = obs_y;
         end
         S_TGT: begin
            rd_x = x1_ff;
            rd_y = y1_ff;
         end
         default: begin
            rd_x = px_ff;
            rd_y = py_ff;
         end
      endcase
   end
   assign rd_addr = hlos_pkg::ADDR_BITS'(rd_y) * hlos_pkg::ADDR_BITS'(hlos_pkg::MAX_WIDTH)
                  + hlos_pkg::ADDR_BITS'(rd_x);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hmem[wr_addr] <= hlos_pkg::HEIGHT_BITS'(q_head.hv);
      end
      rd_data_ff <= hmem[rd_addr];
   end

   // Starting ray value A*steps
   assign mul_a     = hlos_pkg::RAY_BITS'(a_ff);
   assign mul_s     = hlos_pkg::RAY_BITS'(steps_ff);
   assign ray_start = mul_a * mul_s;

   // Error terms: walk offset is round(adx*k/steps), half away from zero
   assign two_steps = hlos_pkg::ERR_BITS'({steps_ff, 1'b0});
   assign ex_sum    = ex_ff + hlos_pkg::ERR_BITS'({adx_ff, 1'b0});
   assign ey_sum    = ey_ff + hlos_pkg::ERR_BITS'({ady_ff, 1'b0});

   // Control and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         v1_ff        <= 1'b0;
         l1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         l2_ff        <= 1'b0;
         shadow_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == S_WALK);
         l1_ff <= (state_ff == S_WALK) && (left_ff == hlos_pkg::STEP_BITS'(1));
         v2_ff <= v1_ff;
         l2_ff <= l1_ff;
         // loaded when a query finishes, cleared once the transfer is taken
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (v2_ff && hit) begin
            shadow_ff <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_pop && q_head.is_query) begin
                  x1_ff     <= q_head.x;
                  y1_ff     <= q_head.y;
                  adx_ff    <= adx_in;
                  ady_ff    <= ady_in;
                  xneg_ff   <= (q_head.x < obs_x);
                  yneg_ff   <= (q_head.y < obs_y);
                  steps_ff  <= steps_in;
                  shadow_ff <= 1'b0;
                  state_ff  <= S_OBS;
               end
            end
            S_OBS: begin
               px_ff    <= obs_x;
               py_ff    <= obs_y;
               ex_ff    <= hlos_pkg::ERR_BITS'(steps_ff);
               ey_ff    <= hlos_pkg::ERR_BITS'(steps_ff);
               left_ff  <= steps_ff;
               state_ff <= S_TGT;
            end
            S_TGT: begin
               // observer height is on the read port now
               a_ff <= hlos_pkg::AB_BITS'(rd_data_ff)
                     + hlos_pkg::AB_BITS'($signed(cfg.observer_offset));
               state_ff <= S_AB;
            end
            S_AB: begin
               b_ff <= hlos_pkg::AB_BITS'(rd_data_ff)
                     + hlos_pkg::AB_BITS'($signed(cfg.target_offset));
               state_ff <= S_MUL;
            end
            S_MUL: begin
               ray_ff   <= ray_start;
               dlt_ff   <= hlos_pkg::DLT_BITS'(b_ff) - hlos_pkg::DLT_BITS'(a_ff);
               state_ff <= S_WALK;
            end
            S_WALK: begin
               // one walk point issued per cycle
               ray_ff  <= ray_ff + hlos_pkg::RAY_BITS'(dlt_ff);
               left_ff <= left_ff - 1'b1;
               if (ex_sum >= two_steps) begin
                  ex_ff <= ex_sum - two_steps;
                  px_ff <= xneg_ff ? (px_ff - 1'b1) : (px_ff + 1'b1);
               end else begin
                  ex_ff <= ex_sum;
               end
               if (ey_sum >= two_steps) begin
                  ey_ff <= ey_sum - two_steps;
                  py_ff <= yneg_ff ? (py_ff - 1'b1) : (py_ff + 1'b1);
               end else begin
                  ey_ff <= ey_sum;
               end
               if (left_ff == hlos_pkg::STEP_BITS'(1)) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               // last point reaches the compare stage
               if (l2_ff) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_x_ff      <= x1_ff;
                  rsp_y_ff      <= y1_ff;
                  rsp_shadow_ff <= shadow_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Check pipeline payload
   always_ff @(posedge clock) begin
      ray1_ff <= ray_ff;
      ray2_ff <= ray1_ff;
      gnd2_ff <= hlos_pkg::GND_BITS'(rd_data_ff) * hlos_pkg::GND_BITS'(steps_ff);
   end

   assign hit = (ray2_ff < $signed(hlos_pkg::RAY_BITS'(gnd2_ff)));

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_target_x = rsp_x_ff;
   assign rsp_target_y = rsp_y_ff;
   assign rsp_shadowed = rsp_shadow_ff;

endmodule

### sv/heightmap_line_of_sight_top.sv
// Top level of the heightmap line-of-sight block: registers, front, queue, back end.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/req_tready req_tdata {cell_x, cell_y, height_value},
//                                             req_tuser kind
//   rsp      out        rsp_tvalid/rsp_tready rsp_tdata {target_x, target_y, shadowed}
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// A write completes in the back end when it is popped from the queue. A query's
// run time grows with steps (steps = max(|dx|,|dy|), at least 1), since the walker
// issues one height-store read per walk point.
// The front takes one transfer per cycle while the four-entry queue has room.
// Reset is synchronous; the height store is not cleared.
// A finished result waits in the output register while the back end keeps
// draining writes; the next query waits only for that register to free up.
`timescale 1ns / 1ps
module heightmap_line_of_sight_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hlos_pkg::REQ_BITS-1:0]  req_tdata,  // cell_x, cell_y, height_value, zeros
   input  logic                           req_tuser,  // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hlos_pkg::RSP_BITS-1:0]  rsp_tdata,  // target_x, target_y, shadowed, zeros
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hlos_pkg::IDX_BITS-1:0]  csr_index,
   input  logic [hlos_pkg::OFS_BITS-1:0]  csr_data
);

   hlos_pkg::cfg_type   cfg_ff;
   hlos_pkg::qstat_type q_stat;
   hlos_pkg::item_type  q_item;
   hlos_pkg::item_type  q_head;
   logic                q_push;
   logic                q_pop;
   logic [hlos_pkg::CRD_BITS-1:0] rsp_target_x;
   logic [hlos_pkg::CRD_BITS-1:0] rsp_target_y;
   logic                          rsp_shadowed;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width       <= hlos_pkg::DIM_BITS'(512);
         cfg_ff.map_height      <= hlos_pkg::DIM_BITS'(512);
         cfg_ff.observer_x      <= '0;
         cfg_ff.observer_y      <= '0;
         cfg_ff.observer_offset <= '0;
         cfg_ff.target_offset   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hlos_pkg::REG_MAP_WIDTH: begin
               cfg_ff.map_width <= csr_data[hlos_pkg::DIM_BITS-1:0];
            end
            hlos_pkg::REG_MAP_HEIGHT: begin
               cfg_ff.map_height <= csr_data[hlos_pkg::DIM_BITS-1:0];
            end
            hlos_pkg::REG_OBSERVER_X: begin
               cfg_ff.observer_x <= csr_data[hlos_pkg::CRD_BITS-1:0];
            end
            hlos_pkg::REG_OBSERVER_Y: begin
               cfg_ff.observer_y <= csr_data[hlos_pkg::CRD_BITS-1:0];
            end
            hlos_pkg::REG_OBSERVER_OFFSET: begin
               cfg_ff.observer_offset <= csr_data;
            end
            hlos_pkg::REG_TARGET_OFFSET: begin
               cfg_ff.target_offset <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   hlos_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   hlos_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head_item (q_head),
      .stat      (q_stat)
   );

   hlos_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_head       (q_head),
      .q_stat       (q_stat),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_target_x (rsp_target_x),
      .rsp_target_y (rsp_target_y),
      .rsp_shadowed (rsp_shadowed)
   );

   // Pack result fields, lowest first
   assign rsp_tdata = {(hlos_pkg::RSP_BITS - 2*hlos_pkg::CRD_BITS - 1)'(0),
                       rsp_shadowed, rsp_target_y, rsp_target_x};

   // Queue status never claims full and empty together
   a_qstat_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty at once");

   // Back end pops only a present item
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   // Front pushes only into free space
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("push into full queue");

endmodule

### tb/tb_top.sv
// Testbench for the heightmap line-of-sight block: predictor, scoreboard, stream drivers.
`timescale 1ns / 1ps
module tb_top;

   localparam int     CLK_HALF      = 5;
   localparam int     RESET_CYCLES  = 11;
   localparam int     SETTLE_CYCLES = 600;      // longer than one full-size query
   localparam int     HOLD_CYCLES   = 2000;     // long receiver hold-off
   localparam longint CYCLE_LIMIT   = 4000000;

   // One visibility answer as the block should report it
   typedef struct {
      bit [hlos_pkg::CRD_BITS-1:0] x;
      bit [hlos_pkg::CRD_BITS-1:0] y;
      bit                          shadowed;
   } verdict_type;

   // Store addresses touched by a query: observer, target, then walk points
   typedef int unsigned cell_list_type[$];

   // Scoreboard: own copy of registers and terrain, queue of pending verdicts
   class sight_scoreboard;
      localparam int REPORT_LIMIT = 10;

      bit [hlos_pkg::DIM_BITS-1:0]    map_w;
      bit [hlos_pkg::DIM_BITS-1:0]    map_h;
      bit [hlos_pkg::CRD_BITS-1:0]    obs_x;
      bit [hlos_pkg::CRD_BITS-1:0]    obs_y;
      bit [hlos_pkg::OFS_BITS-1:0]    obs_ofs;
      bit [hlos_pkg::OFS_BITS-1:0]    tgt_ofs;
      bit [hlos_pkg::HEIGHT_BITS-1:0] heights [hlos_pkg::STORE_DEPTH];
      verdict_type                    pending_verdicts[$];
      int                             mismatches;

      function new();
         map_w      = hlos_pkg::DIM_BITS'(hlos_pkg::MAX_WIDTH);
         map_h      = hlos_pkg::DIM_BITS'(hlos_pkg::MAX_HEIGHT);
         obs_x      = '0;
         obs_y      = '0;
         obs_ofs    = '0;
         tgt_ofs    = '0;
         mismatches = 0;
      endfunction

      // Map dimension in use, forced into 1..max_dim
      function int unsigned span(bit [hlos_pkg::DIM_BITS-1:0] d, int unsigned max_dim);
         if (d == 0) return 1;
         if (d > max_dim) return max_dim;
         return d;
      endfunction

      function bit [hlos_pkg::CRD_BITS-1:0] clip(bit [hlos_pkg::CRD_BITS-1:0] v,
                                                 bit [hlos_pkg::DIM_BITS-1:0] d,
                                                 int unsigned max_dim);
         int unsigned lim;
         lim = span(d, max_dim) - 1;
         return (v > lim) ? hlos_pkg::CRD_BITS'(lim) : v;
      endfunction

      // num/den rounded half away from zero, den > 0
      function longint round_away(longint num, longint den);
         if (num < 0) return -((2 * (-num) + den) / (2 * den));
         return (2 * num + den) / (2 * den);
      endfunction

      function cell_list_type ray_cells(bit [hlos_pkg::CRD_BITS-1:0] cx,
                                        bit [hlos_pkg::CRD_BITS-1:0] cy);
         cell_list_type cells;
         int x0, y0, x1, y1, dx, dy, adx, ady, steps, px, py;
         x0 = clip(obs_x, map_w, hlos_pkg::MAX_WIDTH);
         y0 = clip(obs_y, map_h, hlos_pkg::MAX_HEIGHT);
         x1 = clip(cx, map_w, hlos_pkg::MAX_WIDTH);
         y1 = clip(cy, map_h, hlos_pkg::MAX_HEIGHT);
         dx = x1 - x0;
         dy = y1 - y0;
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         steps = (adx > ady) ? adx : ady;
         if (steps == 0) steps = 1;
         cells = {cells, y0 * hlos_pkg::MAX_WIDTH + x0};
         cells = {cells, y1 * hlos_pkg::MAX_WIDTH + x1};
         for (int k = 0; k < steps; k++) begin
            px = x0 + int'(round_away(longint'(dx) * k, steps));
            py = y0 + int'(round_away(longint'(dy) * k, steps));
            cells = {cells, py * hlos_pkg::MAX_WIDTH + px};
         end
         return cells;
      endfunction

      // Ray from observer top to target top, compared against ground times steps
      function bit ray_is_blocked(cell_list_type cells);
         longint a, b, steps;
         a = longint'(heights[cells[0]]) + longint'($signed(obs_ofs));
         b = longint'(heights[cells[1]]) + longint'($signed(tgt_ofs));
         steps = cells.size() - 2;
         for (longint k = 0; k < steps; k++) begin
            if (a * (steps - k) + b * k < longint'(heights[cells[k + 2]]) * steps)
               return 1'b1;
         end
         return 1'b0;
      endfunction

      function void set_reg(hlos_pkg::reg_index_type idx, bit [hlos_pkg::OFS_BITS-1:0] data);
         case (idx)
            hlos_pkg::REG_MAP_WIDTH:       map_w   = data[hlos_pkg::DIM_BITS-1:0];
            hlos_pkg::REG_MAP_HEIGHT:      map_h   = data[hlos_pkg::DIM_BITS-1:0];
            hlos_pkg::REG_OBSERVER_X:      obs_x   = data[hlos_pkg::CRD_BITS-1:0];
            hlos_pkg::REG_OBSERVER_Y:      obs_y   = data[hlos_pkg::CRD_BITS-1:0];
            hlos_pkg::REG_OBSERVER_OFFSET: obs_ofs = data;
            hlos_pkg::REG_TARGET_OFFSET:   tgt_ofs = data;
            default: ;
         endcase
      endfunction

      // Accepted request: update terrain or queue the verdict it must produce
      function void take_item(bit kind, bit [hlos_pkg::CRD_BITS-1:0] cx,
                              bit [hlos_pkg::CRD_BITS-1:0] cy,
                              bit [hlos_pkg::HV_BITS-1:0] hv);
         cell_list_type cells;
         verdict_type   v;
         if (kind == hlos_pkg::KIND_WRITE) begin
            if (cx < span(map_w, hlos_pkg::MAX_WIDTH) && cy < span(map_h, hlos_pkg::MAX_HEIGHT))
               heights[cy * hlos_pkg::MAX_WIDTH + cx] = hlos_pkg::HEIGHT_BITS'(hv);
            return;
         end
         cells = ray_cells(cx, cy);
         v.x = hlos_pkg::CRD_BITS'(cells[1] % hlos_pkg::MAX_WIDTH);
         v.y = hlos_pkg::CRD_BITS'(cells[1] / hlos_pkg::MAX_WIDTH);
         v.shadowed = ray_is_blocked(cells);
         pending_verdicts = {pending_verdicts, v};
      endfunction

      function void check_result(logic [hlos_pkg::RSP_BITS-1:0] d);
         verdict_type v;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: x=%0d y=%0d shadowed=%0d",
                        d[hlos_pkg::CRD_BITS-1:0],
                        d[2*hlos_pkg::CRD_BITS-1:hlos_pkg::CRD_BITS],
                        d[2*hlos_pkg::CRD_BITS]);
            return;
         end
         v = pending_verdicts.pop_front();
         if (d[hlos_pkg::CRD_BITS-1:0] !== v.x ||
             d[2*hlos_pkg::CRD_BITS-1:hlos_pkg::CRD_BITS] !== v.y ||
             d[2*hlos_pkg::CRD_BITS] !== v.shadowed) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"result mismatch: expected x=%0d y=%0d shadowed=%0d, ",
                         "got x=%0d y=%0d shadowed=%0d"},
                        v.x, v.y, v.shadowed,
                        d[hlos_pkg::CRD_BITS-1:0],
                        d[2*hlos_pkg::CRD_BITS-1:hlos_pkg::CRD_BITS],
                        d[2*hlos_pkg::CRD_BITS]);
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [hlos_pkg::REQ_BITS-1:0] req_tdata;   // cell_x, cell_y, height_value, zeros
   logic                          req_tuser;   // kind
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [hlos_pkg::RSP_BITS-1:0] rsp_tdata;   // target_x, target_y, shadowed, zeros
   logic                          csr_valid;
   logic                          csr_ready;
   logic [hlos_pkg::IDX_BITS-1:0] csr_index;
   logic [hlos_pkg::OFS_BITS-1:0] csr_data;

   sight_scoreboard              sb;
   bit                           cell_written [hlos_pkg::STORE_DEPTH];   // cells filled so far
   bit                           no_idle;
   bit                           hold_req;
   bit [hlos_pkg::HV_BITS-1:0]   hv_max;
   longint                       cycle_count = 0;

   heightmap_line_of_sight_top uut (.*);

   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   // Run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic bit [hlos_pkg::HV_BITS-1:0] draw_height();
      return hlos_pkg::HV_BITS'($urandom_range(0, hv_max));
   endfunction

   // One request transfer; called and returns at a falling edge
   task automatic send_item(bit kind, bit [hlos_pkg::CRD_BITS-1:0] cx,
                            bit [hlos_pkg::CRD_BITS-1:0] cy,
                            bit [hlos_pkg::HV_BITS-1:0] hv);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {{(hlos_pkg::REQ_BITS - 2*hlos_pkg::CRD_BITS - hlos_pkg::HV_BITS){1'b0}},
                    hv, cy, cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.take_item(kind, cx, cy, hv);
      @(negedge clock);
   endtask

   task automatic send_write(bit [hlos_pkg::CRD_BITS-1:0] cx, bit [hlos_pkg::CRD_BITS-1:0] cy,
                             bit [hlos_pkg::HV_BITS-1:0] hv);
      if (cx < sb.span(sb.map_w, hlos_pkg::MAX_WIDTH) &&
          cy < sb.span(sb.map_h, hlos_pkg::MAX_HEIGHT))
         cell_written[cy * hlos_pkg::MAX_WIDTH + cx] = 1'b1;
      send_item(hlos_pkg::KIND_WRITE, cx, cy, hv);
   endtask

   // Fill any never-written cell on the ray first, so no undefined sample is read
   task automatic send_query(bit [hlos_pkg::CRD_BITS-1:0] cx, bit [hlos_pkg::CRD_BITS-1:0] cy);
      cell_list_type cells;
      cells = sb.ray_cells(cx, cy);
      foreach (cells[i]) begin
         if (!cell_written[cells[i]])
            send_write(hlos_pkg::CRD_BITS'(cells[i] % hlos_pkg::MAX_WIDTH),
                       hlos_pkg::CRD_BITS'(cells[i] / hlos_pkg::MAX_WIDTH),
                       draw_height());
      end
      send_item(hlos_pkg::KIND_QUERY, cx, cy, hlos_pkg::HV_BITS'($urandom));
   endtask

   task automatic csr_write(hlos_pkg::reg_index_type idx, bit [hlos_pkg::OFS_BITS-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic program_map(bit [15:0] w, bit [15:0] h, bit [15:0] ox, bit [15:0] oy,
                              bit [15:0] oo, bit [15:0] tofs);
      csr_write(hlos_pkg::REG_MAP_WIDTH, w);
      csr_write(hlos_pkg::REG_MAP_HEIGHT, h);
      csr_write(hlos_pkg::REG_OBSERVER_X, ox);
      csr_write(hlos_pkg::REG_OBSERVER_Y, oy);
      csr_write(hlos_pkg::REG_OBSERVER_OFFSET, oo);
      csr_write(hlos_pkg::REG_TARGET_OFFSET, tofs);
      csr_valid = 1'b0;
   endtask

   // Sender pauses until every verdict is in, then lets trailing writes finish
   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Random small map, observer and offsets, then a mix of writes and queries
   task automatic random_phase(int n_items);
      bit [15:0]                   w, h, ox, oy, oo, tofs;
      int unsigned                 we, he;
      bit [hlos_pkg::CRD_BITS-1:0] cx, cy;
      w = 16'($urandom_range(1, 16));
      h = 16'($urandom_range(1, 16));
      // junk above the register width must be dropped
      if ($urandom_range(0, 3) == 0) w[15:hlos_pkg::DIM_BITS] = 6'($urandom);
      if ($urandom_range(0, 3) == 0) h[15:hlos_pkg::DIM_BITS] = 6'($urandom);
      we = sb.span(w[hlos_pkg::DIM_BITS-1:0], hlos_pkg::MAX_WIDTH);
      he = sb.span(h[hlos_pkg::DIM_BITS-1:0], hlos_pkg::MAX_HEIGHT);
      ox = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 511))
                                       : 16'($urandom_range(0, we - 1));
      oy = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 511))
                                       : 16'($urandom_range(0, he - 1));
      if ($urandom_range(0, 3) == 0) ox[15:hlos_pkg::CRD_BITS] = 7'($urandom);
      if ($urandom_range(0, 3) == 0) oy[15:hlos_pkg::CRD_BITS] = 7'($urandom);
      // height range and offsets chosen so both verdicts turn up
      case ($urandom_range(0, 2))
         0: begin
            hv_max = 16'hFFFF;
            oo     = 16'($urandom);
            tofs   = 16'($urandom);
         end
         1: begin
            hv_max = 16'd255;
            oo     = 16'($urandom_range(0, 300));
            tofs   = 16'($urandom_range(0, 600) - 300);
         end
         default: begin
            hv_max = 16'd4095;
            oo     = 16'($urandom_range(0, 2500));
            tofs   = 16'($urandom_range(0, 3000) - 1500);
         end
      endcase
      program_map(w, h, ox, oy, oo, tofs);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 9) < 2) begin
            cx = hlos_pkg::CRD_BITS'($urandom);
            cy = hlos_pkg::CRD_BITS'($urandom);
         end else begin
            cx = hlos_pkg::CRD_BITS'($urandom_range(0, we - 1));
            cy = hlos_pkg::CRD_BITS'($urandom_range(0, he - 1));
         end
         if ($urandom_range(0, 1)) send_write(cx, cy, draw_height());
         else send_query(cx, cy);
      end
      drain();
   endtask

   // Result receiver with per-transfer gaps and one long hold-off on request
   initial begin : result_sink
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_result(rsp_tdata);
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
      end
   end

   initial begin
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = hlos_pkg::REG_MAP_WIDTH;
      csr_data   = '0;
      hv_max     = 16'hFFFF;
      no_idle    = 1'b0;
      hold_req   = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: corner cells, observer on target, short rays
      send_write(9'd0, 9'd0, 16'hFFFF);
      send_write(9'd511, 9'd511, 16'h0000);
      send_query(9'd0, 9'd0);
      send_write(9'd0, 9'd0, 16'h0000);
      send_write(9'd1, 9'd0, 16'h8001);
      send_query(9'd1, 9'd0);
      send_query(9'd3, 9'd1);
      send_query(9'd1, 9'd3);
      drain();

      // Zero-size map saturates to one cell; observer off map; offsets at limits
      program_map(16'd0, 16'd0, 16'd511, 16'd511, 16'h8000, 16'h7FFF);
      send_write(9'd5, 9'd5, 16'd77);      // off map, dropped
      send_write(9'd0, 9'd0, 16'd1234);
      send_query(9'd511, 9'd511);          // lands on the observer, negative offset
      drain();

      // Width above range saturates to full width; two rows; long walk from the edge
      program_map(16'h03FF, 16'd2, 16'd511, 16'd1, 16'h7FFF, 16'h8000);
      send_write(9'd3, 9'd200, 16'd9);     // row off map, dropped
      send_query(9'd384, 9'd0);
      send_query(9'd450, 9'd1);
      drain();

      // Receiver holds off while the sender keeps pushing
      hold_req = 1'b1;
      random_phase(40);

      for (int p = 0; p < 8; p++) begin
         random_phase(35);
      end

      if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
